[hw/rtl/day_color_gradient_lookup_unit_assert.svh]
// Assertion macros used by the top level of the day color gradient lookup RTL
`ifndef DAY_COLOR_GRADIENT_LOOKUP_UNIT_ASSERT_SVH
`define DAY_COLOR_GRADIENT_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DCGL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dcgl assertion failed");

// next-cycle implication, disabled while in reset
`define DCGL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dcgl assertion failed");

`endif

[hw/rtl/dcgl_pkg.sv]
// Package with types, constants and helper functions of the day color gradient lookup
`timescale 1ns / 1ps

package dcgl_pkg;

    localparam int DAY_W         = 9;
    localparam int COLOR_BITS    = 8;
    localparam int CHANNELS      = 3;
    localparam int COLOR_W       = CHANNELS * COLOR_BITS;
    localparam int DAYS_PER_YEAR = 365;
    localparam int KEY_POINTS    = 4;
    localparam int NUM_KEY_REGS  = 4;
    localparam int MONTHS        = 12;
    localparam int DIV_STEPS     = COLOR_BITS;
    localparam int NUM_W         = DAY_W + COLOR_BITS;
    localparam int DVS_W         = DAY_W + COLOR_BITS - 1;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    typedef logic [DAY_W-1:0]      day_t;
    typedef logic [COLOR_W-1:0]    color_t;
    typedef logic [COLOR_BITS-1:0] chan_t;

    typedef enum logic [1:0] {
        MARK_GRADIENT,
        MARK_MONTH,
        MARK_KEY,
        MARK_UNLIT
    } marker_t;

    typedef enum logic [2:0] {
        REG_KEY_DAY_0,
        REG_KEY_DAY_1,
        REG_KEY_DAY_2,
        REG_KEY_DAY_3,
        REG_KEY_COLOR_0,
        REG_KEY_COLOR_1,
        REG_KEY_COLOR_2,
        REG_KEY_COLOR_3
    } reg_idx_t;

    localparam logic [NUM_KEY_REGS-1:0][DAY_W-1:0] KEY_DAY_RST =
        {9'd355, 9'd266, 9'd172, 9'd80};
    localparam logic [NUM_KEY_REGS-1:0][COLOR_W-1:0] KEY_COLOR_RST =
        {24'h43545A, 24'hA52A2A, 24'h645A00, 24'h006400};

    localparam logic [4:0] MONTH_LEN [MONTHS] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef struct packed {
        day_t    len;
        day_t    off;
        color_t  c0;
        color_t  c1;
        marker_t marker;
    } seg_item_t;

    typedef struct packed {
        logic [CHANNELS-1:0][NUM_W-1:0]      rem;
        logic [CHANNELS-1:0][COLOR_BITS-1:0] quo;
        logic [DVS_W-1:0]                    dvs;
        marker_t                             marker;
    } div_item_t;

    function automatic logic is_month_start(day_t d);
        logic hit;
        day_t acc;
        hit = 1'b0;
        acc = '0;
        for (int m = 0; m < MONTHS; m++) begin
            if (acc == d) begin
                hit = 1'b1;
            end
            acc = acc + day_t'(MONTH_LEN[m]);
        end
        return hit;
    endfunction

    function automatic day_t wrap_day(day_t k);
        return (k >= day_t'(DAYS_PER_YEAR)) ? k - day_t'(DAYS_PER_YEAR) : k;
    endfunction

    function automatic day_t fwd_dist(day_t from, day_t to);
        logic [DAY_W:0] t;
        if (to >= from) begin
            t = {1'b0, to} - {1'b0, from};
        end else begin
            t = {1'b0, to} + (DAY_W+1)'(DAYS_PER_YEAR) - {1'b0, from};
        end
        return t[DAY_W-1:0];
    endfunction

endpackage

[hw/rtl/dcgl_seg.sv]
// Segment select stage: finds the key segment, offset and marker of a day
`timescale 1ns / 1ps

module dcgl_seg (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  dcgl_pkg::day_t                                        in_day,
    input  logic [dcgl_pkg::NUM_KEY_REGS-1:0][dcgl_pkg::DAY_W-1:0]   key_day,
    input  logic [dcgl_pkg::NUM_KEY_REGS-1:0][dcgl_pkg::COLOR_W-1:0] key_color,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output dcgl_pkg::seg_item_t                                   out_item
);
    import dcgl_pkg::*;

    logic      valid_reg, valid_next;
    seg_item_t item_reg, item_next;
    seg_item_t built;
    day_t      kd [KEY_POINTS];
    day_t      seg_len, seg_off;
    day_t      len_sel, off_sel;
    color_t    c0_sel, c1_sel;
    logic      grad_hit, key_hit;

    always_comb begin
        for (int i = 0; i < KEY_POINTS; i++) begin
            kd[i] = wrap_day(key_day[i]);
        end
    end

    always_comb begin
        seg_len  = '0;
        seg_off  = '0;
        len_sel  = day_t'(1);
        off_sel  = '0;
        c0_sel   = '0;
        c1_sel   = '0;
        grad_hit = 1'b0;
        key_hit  = 1'b0;
        for (int i = 0; i < KEY_POINTS; i++) begin
            seg_len = fwd_dist(kd[i], kd[(i + 1) % KEY_POINTS]);
            seg_off = fwd_dist(kd[i], in_day);
            if (seg_len != '0 && seg_off < seg_len) begin
                grad_hit = 1'b1;
                len_sel  = seg_len;
                off_sel  = seg_off;
                c0_sel   = key_color[i];
                c1_sel   = key_color[(i + 1) % KEY_POINTS];
            end
            if (kd[i] == in_day) begin
                key_hit = 1'b1;
            end
        end
    end

    always_comb begin
        built.len    = len_sel;
        built.off    = off_sel;
        built.c0     = c0_sel;
        built.c1     = c1_sel;
        built.marker = MARK_GRADIENT;
        if (in_day >= day_t'(DAYS_PER_YEAR)) begin
            built.marker = MARK_UNLIT;
        end else if (key_hit) begin
            built.marker = MARK_KEY;
        end else if (is_month_start(in_day)) begin
            built.marker = MARK_MONTH;
        end else if (!grad_hit) begin
            built.marker = MARK_UNLIT;
        end
        if (built.marker != MARK_GRADIENT) begin
            built.len = day_t'(1);
            built.off = '0;
            built.c0  = '0;
            built.c1  = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            item_next = built;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/dcgl_num.sv]
// Numerator stage: weights the two key colors of each channel by segment position
`timescale 1ns / 1ps

module dcgl_num (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dcgl_pkg::seg_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dcgl_pkg::div_item_t  out_item
);
    import dcgl_pkg::*;

    logic      valid_reg, valid_next;
    div_item_t item_reg, item_next;
    div_item_t built;
    day_t      w0;
    chan_t     a0, a1;

    always_comb begin
        w0 = in_item.len - in_item.off;
        a0 = '0;
        a1 = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            a0 = in_item.c0[ch*COLOR_BITS +: COLOR_BITS];
            a1 = in_item.c1[ch*COLOR_BITS +: COLOR_BITS];
            built.rem[ch] = {{DAY_W{1'b0}}, a0} * {{COLOR_BITS{1'b0}}, w0}
                          + {{DAY_W{1'b0}}, a1} * {{COLOR_BITS{1'b0}}, in_item.off};
            built.quo[ch] = '0;
        end
        built.dvs    = {in_item.len, {(COLOR_BITS-1){1'b0}}};
        built.marker = in_item.marker;
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            item_next = built;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/dcgl_div_cell.sv]
// Divider cell: one restoring division step on all three channels
`timescale 1ns / 1ps

module dcgl_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dcgl_pkg::div_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dcgl_pkg::div_item_t  out_item
);
    import dcgl_pkg::*;

    logic      valid_reg, valid_next;
    div_item_t item_reg, item_next;
    div_item_t built;
    logic      ge;

    always_comb begin
        ge = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            ge = in_item.rem[ch] >= {1'b0, in_item.dvs};
            built.rem[ch] = ge ? in_item.rem[ch] - {1'b0, in_item.dvs} : in_item.rem[ch];
            built.quo[ch] = {in_item.quo[ch][COLOR_BITS-2:0], ge};
        end
        built.dvs    = in_item.dvs >> 1;
        built.marker = in_item.marker;
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            item_next = built;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/day_color_gradient_lookup_unit.sv]
// Top level of the day color gradient lookup: register port, stage chain, result channel
//
// Send a day of the year on s_day with s_valid; the shown LED color comes back on
// m_red, m_green, m_blue with m_marker (gradient, month start, key day or unlit).
// Four key days and four key colors sit in APB registers at byte addresses 0..28;
// write them only while no day is in flight. pready is always high.
// The path from an input transfer to m_valid runs through one segment select
// stage, one numerator stage and a row of 8 divider cells, one quotient bit each.
// Throughput: one day per cycle; every stage is a register with its own valid, so
// a new day is taken in every cycle while results flow.
// When the receiver stalls, results pile up in the chain, one per stage; s_ready
// stays high as long as the first stage is empty or can move on, and falls once
// the chain is full. Nothing is dropped.
// Reset (aresetn low at a clock edge) empties the chain and loads the default
// key days 80, 172, 266, 355 and their default colors.
`timescale 1ns / 1ps

module day_color_gradient_lookup_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcgl_pkg::ADDR_W-1:0]   paddr,
    input  logic [dcgl_pkg::DATA_W-1:0]   pwdata,
    output logic [dcgl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dcgl_pkg::day_t                s_day,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dcgl_pkg::chan_t               m_red,
    output dcgl_pkg::chan_t               m_green,
    output dcgl_pkg::chan_t               m_blue,
    output logic [1:0]                    m_marker
);
    import dcgl_pkg::*;

    `include "day_color_gradient_lookup_unit_assert.svh"

    logic [NUM_KEY_REGS-1:0][DAY_W-1:0]   key_day_reg, key_day_next;
    logic [NUM_KEY_REGS-1:0][COLOR_W-1:0] key_color_reg, key_color_next;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;

    logic      seg_valid, seg_ready;
    seg_item_t seg_item;

    logic      chain_valid [DIV_STEPS+1];
    logic      chain_ready [DIV_STEPS+1];
    div_item_t chain_item  [DIV_STEPS+1];

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb begin
        key_day_next   = key_day_reg;
        key_color_next = key_color_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_KEY_DAY_0:   key_day_next[0]   = pwdata[DAY_W-1:0];
                REG_KEY_DAY_1:   key_day_next[1]   = pwdata[DAY_W-1:0];
                REG_KEY_DAY_2:   key_day_next[2]   = pwdata[DAY_W-1:0];
                REG_KEY_DAY_3:   key_day_next[3]   = pwdata[DAY_W-1:0];
                REG_KEY_COLOR_0: key_color_next[0] = pwdata[COLOR_W-1:0];
                REG_KEY_COLOR_1: key_color_next[1] = pwdata[COLOR_W-1:0];
                REG_KEY_COLOR_2: key_color_next[2] = pwdata[COLOR_W-1:0];
                REG_KEY_COLOR_3: key_color_next[3] = pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_day_reg   <= KEY_DAY_RST;
            key_color_reg <= KEY_COLOR_RST;
        end else begin
            key_day_reg   <= key_day_next;
            key_color_reg <= key_color_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_KEY_DAY_0:   prdata = DATA_W'(key_day_reg[0]);
            REG_KEY_DAY_1:   prdata = DATA_W'(key_day_reg[1]);
            REG_KEY_DAY_2:   prdata = DATA_W'(key_day_reg[2]);
            REG_KEY_DAY_3:   prdata = DATA_W'(key_day_reg[3]);
            REG_KEY_COLOR_0: prdata = DATA_W'(key_color_reg[0]);
            REG_KEY_COLOR_1: prdata = DATA_W'(key_color_reg[1]);
            REG_KEY_COLOR_2: prdata = DATA_W'(key_color_reg[2]);
            REG_KEY_COLOR_3: prdata = DATA_W'(key_color_reg[3]);
            default:         prdata = '0;
        endcase
    end

    dcgl_seg u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_day    (s_day),
        .key_day   (key_day_reg),
        .key_color (key_color_reg),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_item  (seg_item)
    );

    dcgl_num u_num (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_item   (seg_item),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        dcgl_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    assign chain_ready[DIV_STEPS] = m_ready;
    assign m_valid  = chain_valid[DIV_STEPS];
    assign m_red    = chain_item[DIV_STEPS].quo[2];
    assign m_green  = chain_item[DIV_STEPS].quo[1];
    assign m_blue   = chain_item[DIV_STEPS].quo[0];
    assign m_marker = chain_item[DIV_STEPS].marker;

    `DCGL_ASSERT_NOW(a_black_unless_gradient, aclk, aresetn,
        m_valid && m_marker != MARK_GRADIENT,
        m_red == '0 && m_green == '0 && m_blue == '0)
    `DCGL_ASSERT_NOW(a_ready_when_front_empty, aclk, aresetn, !seg_valid, s_ready)
    `DCGL_ASSERT_NEXT(a_key_day_0_write, aclk, aresetn,
        cfg_wr && cfg_idx == REG_KEY_DAY_0,
        key_day_reg[0] == $past(pwdata[DAY_W-1:0]))

endmodule
